// ===== src/jsf_pkg.sv =====
// ============================================================================
// jsf_pkg
// Shared types and constants for the jet substructure features unit.
// ============================================================================
package jsf_pkg;

    localparam int MAX_CONSTITUENTS = 64;

    localparam logic [12:0] PI_FX     = 13'd3217;
    localparam logic [12:0] TWO_PI_FX = 13'd6434;

    localparam logic [17:0] M18      = 18'h3FFFF;
    localparam logic [6:0]  M7       = 7'h7F;
    localparam logic [19:0] DSUM_MAX = 20'hFFFFF;
    localparam logic [41:0] SSUM_MAX = 42'h3FFFFFFFFFF;

    localparam logic [16:0] FRAC_ONE = 17'd65536;
    localparam logic [13:0] ANG_MAX  = 14'd16383;

    // configuration register indexes
    localparam logic [1:0] REG_RHO_MIN    = 2'd0;
    localparam logic [1:0] REG_RHO_MAX    = 2'd1;
    localparam logic [1:0] REG_JET_PT_MIN = 2'd2;

    // shared unit operations
    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    // command to the shared divide / square-root unit
    typedef struct packed {
        logic        start;
        logic        op;
        logic [5:0]  nbits;   // quotient bits (divide) or root bits (sqrt)
        logic [41:0] a;       // dividend or radicand
        logic [17:0] b;       // divisor
    } cmd_t;

endpackage

// ===== src/jsf_root_div.sv =====
// ============================================================================
// jsf_root_div
// Shared restoring divider and digit-by-digit square root, one result bit
// per cycle through a single subtract-and-compare.
// ============================================================================
module jsf_root_div
(
    input  logic          clk,
    input  logic          rst_n,
    input  jsf_pkg::cmd_t cmd,
    output logic          done,
    output logic [41:0]   result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        op_reg;
    logic [41:0] a_reg;
    logic [17:0] b_reg;
    logic [24:0] rem_reg;
    logic [41:0] q_reg;

    logic [5:0]  i_div, i_hi, i_lo;
    logic [24:0] rem_sh, trial, rem_new;
    logic [25:0] diff;
    logic        ge;

    always_comb
    begin
        i_div = cnt_reg - 6'd1;
        i_hi  = {cnt_reg[4:0], 1'b0} - 6'd1;
        i_lo  = {cnt_reg[4:0], 1'b0} - 6'd2;
        if (op_reg == jsf_pkg::OP_SQRT)
        begin
            rem_sh = {rem_reg[22:0], a_reg[i_hi], a_reg[i_lo]};
            trial  = {2'b00, q_reg[20:0], 2'b01};
        end
        else
        begin
            rem_sh = {rem_reg[23:0], a_reg[i_div]};
            trial  = {7'd0, b_reg};
        end
        diff    = {1'b0, rem_sh} - {1'b0, trial};
        ge      = !diff[25];
        rem_new = ge ? diff[24:0] : rem_sh;
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.nbits;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg  <= cmd.op;
            a_reg   <= cmd.a;
            b_reg   <= cmd.b;
            rem_reg <= 25'd0;
            q_reg   <= 42'd0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new;
            q_reg   <= {q_reg[40:0], ge};
        end
    end

    assign done   = done_reg;
    assign result = q_reg;

endmodule

// ===== src/jet_substructure_features_unit.sv =====
// ============================================================================
// jet_substructure_features_unit
// Per-jet substructure observables from a stream of constituents.
// ============================================================================
// One constituent item is taken at a time; s_tready is low while it is
// processed. A non-final item passes through the accept state, five squarings
// on the shared multiplier, and two square roots (19 and 15 root bits) and an
// 18-bit divide by n on one shared bit-serial divide/square-root unit. With a
// zero count the divide is skipped. The final item of a jet then adds the lead
// fraction (34-bit divide, skipped when it saturates or jet pt is zero),
// angularity (20-bit divide), pt spread (42-bit divide then 21-bit root) and
// the load of the output register; a zero count skips angularity and pt
// spread. The result waits in an output register and the next jet's items are
// taken meanwhile; a further result stalls until that register is free.
module jet_substructure_features_unit
(
    input  logic         clk,
    input  logic         rst_n,
    // jet_pt[17:0] jet_eta[31:18] jet_phi[44:32] n_constituents[51:45]
    // part_pt[69:52] part_eta[83:70] part_phi[96:84] vertex_x[115:97]
    // vertex_y[134:116], zero pad [135]
    input  logic [135:0] s_tdata,
    input  logic         s_tlast,   // last_in_jet
    input  logic         s_tvalid,
    output logic         s_tready,
    // constituent_count[6:0] secondary_count[13:7] max_radius[31:14]
    // lead_fraction[48:32] angularity[62:49] pt_spread[80:63]
    // jet_pass[81] count_error[82], zero pad [87:83]
    output logic [87:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [17:0]  cfg_data
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_SQX     = 5'd1;
    localparam logic [4:0] S_SQY     = 5'd2;
    localparam logic [4:0] S_RAD_GO  = 5'd3;
    localparam logic [4:0] S_RAD_WT  = 5'd4;
    localparam logic [4:0] S_SQE     = 5'd5;
    localparam logic [4:0] S_SQP     = 5'd6;
    localparam logic [4:0] S_RDS_GO  = 5'd7;
    localparam logic [4:0] S_RDS_WT  = 5'd8;
    localparam logic [4:0] S_MEAN_GO = 5'd9;
    localparam logic [4:0] S_MEAN_WT = 5'd10;
    localparam logic [4:0] S_DEV     = 5'd11;
    localparam logic [4:0] S_FRAC_GO = 5'd12;
    localparam logic [4:0] S_FRAC_WT = 5'd13;
    localparam logic [4:0] S_ANG_GO  = 5'd14;
    localparam logic [4:0] S_ANG_WT  = 5'd15;
    localparam logic [4:0] S_SDIV_GO = 5'd16;
    localparam logic [4:0] S_SDIV_WT = 5'd17;
    localparam logic [4:0] S_SPR_GO  = 5'd18;
    localparam logic [4:0] S_SPR_WT  = 5'd19;
    localparam logic [4:0] S_OUT     = 5'd20;

    logic [4:0]  state_reg, state_next;

    logic [17:0] rho_min_reg, rho_max_reg, jet_pt_min_reg;

    logic [6:0]  seen_reg, seen_next;
    logic [6:0]  sec_reg, sec_next;
    logic [17:0] peak_reg, peak_next;
    logic [17:0] lead_reg, lead_next;
    logic [19:0] dsum_reg, dsum_next;
    logic [41:0] ssum_reg, ssum_next;
    logic        m_tvalid_reg, m_tvalid_next;

    logic [17:0] jpt_reg, ppt_reg, mean_reg;
    logic [6:0]  n_reg;
    logic [18:0] ax_reg, ay_reg;
    logic [13:0] deta_reg;
    logic [11:0] dphi_reg;
    logic        last_reg;
    logic [37:0] acc_reg;
    logic [16:0] frac_reg;
    logic [13:0] ang_reg;
    logic [17:0] spr_reg;
    logic [87:0] m_tdata_reg;

    // item field views
    logic [17:0]        in_jpt, in_ppt;
    logic signed [13:0] in_jeta, in_peta;
    logic signed [12:0] in_jphi, in_pphi;
    logic [6:0]         in_n, in_n_clamp;
    logic signed [18:0] in_vx, in_vy;

    logic signed [14:0] eta_d;
    logic signed [13:0] phi_d;
    logic signed [19:0] vx_e, vy_e;
    logic [13:0]        deta_w;
    logic [12:0]        dphi_abs;
    logic [11:0]        dphi_w;
    logic [18:0]        ax_w, ay_w;

    logic [18:0] mul_a, mul_b;
    logic [37:0] prod;
    logic [17:0] dev;
    logic [20:0] dsum_add;
    logic [42:0] ssum_add;
    logic        accept, out_free;

    jsf_pkg::cmd_t cmd;
    logic          u_done;
    logic [41:0]   u_res;

    jsf_root_div u_root_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .done   (u_done),
        .result (u_res)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb
    begin
        in_jpt  = s_tdata[17:0];
        in_jeta = s_tdata[31:18];
        in_jphi = s_tdata[44:32];
        in_n    = s_tdata[51:45];
        in_ppt  = s_tdata[69:52];
        in_peta = s_tdata[83:70];
        in_pphi = s_tdata[96:84];
        in_vx   = s_tdata[115:97];
        in_vy   = s_tdata[134:116];

        in_n_clamp = (in_n > 7'(jsf_pkg::MAX_CONSTITUENTS))
                   ? 7'(jsf_pkg::MAX_CONSTITUENTS) : in_n;

        eta_d  = {in_peta[13], in_peta} - {in_jeta[13], in_jeta};
        deta_w = eta_d[14] ? 14'(-eta_d) : eta_d[13:0];

        phi_d    = {in_pphi[12], in_pphi} - {in_jphi[12], in_jphi};
        dphi_abs = phi_d[13] ? 13'(-phi_d) : phi_d[12:0];
        // wrap across pi; beyond two pi the distance is taken as zero
        if (dphi_abs > jsf_pkg::PI_FX)
            dphi_w = (dphi_abs > jsf_pkg::TWO_PI_FX)
                   ? 12'd0 : 12'(jsf_pkg::TWO_PI_FX - dphi_abs);
        else
            dphi_w = dphi_abs[11:0];

        vx_e = {in_vx[18], in_vx};
        vy_e = {in_vy[18], in_vy};
        ax_w = vx_e[19] ? 19'(-vx_e) : vx_e[18:0];
        ay_w = vy_e[19] ? 19'(-vy_e) : vy_e[18:0];
    end

    assign dev = (ppt_reg > mean_reg) ? (ppt_reg - mean_reg) : (mean_reg - ppt_reg);

    always_comb
    begin
        case (state_reg)
            S_SQX:
            begin
                mul_a = ax_reg;
                mul_b = ax_reg;
            end
            S_SQY:
            begin
                mul_a = ay_reg;
                mul_b = ay_reg;
            end
            S_SQE:
            begin
                mul_a = {5'd0, deta_reg};
                mul_b = {5'd0, deta_reg};
            end
            S_SQP:
            begin
                mul_a = {7'd0, dphi_reg};
                mul_b = {7'd0, dphi_reg};
            end
            default:
            begin
                mul_a = {1'b0, dev};
                mul_b = {1'b0, dev};
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign dsum_add = {1'b0, dsum_reg} + {6'd0, u_res[14:0]};
    assign ssum_add = {1'b0, ssum_reg} + {5'd0, prod};

    always_comb
    begin
        state_next    = state_reg;
        seen_next     = seen_reg;
        sec_next      = sec_reg;
        peak_next     = peak_reg;
        lead_next     = lead_reg;
        dsum_next     = dsum_reg;
        ssum_next     = ssum_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (seen_reg != jsf_pkg::M7)
                        seen_next = seen_reg + 7'd1;
                    if (in_ppt > lead_reg)
                        lead_next = in_ppt;
                    state_next = S_SQX;
                end
            end
            S_SQX:
                state_next = S_SQY;
            S_SQY:
                state_next = S_RAD_GO;
            S_RAD_GO:
            begin
                cmd.start  = 1'b1;
                cmd.op     = jsf_pkg::OP_SQRT;
                cmd.nbits  = 6'd19;
                cmd.a      = {4'd0, acc_reg};
                state_next = S_RAD_WT;
            end
            S_RAD_WT:
            begin
                if (u_done)
                begin
                    if ((u_res[18:0] > {1'b0, rho_min_reg})
                        && (u_res[18:0] <= {1'b0, rho_max_reg}))
                    begin
                        if (sec_reg != jsf_pkg::M7)
                            sec_next = sec_reg + 7'd1;
                        if (u_res[17:0] > peak_reg)
                            peak_next = u_res[17:0];
                    end
                    state_next = S_SQE;
                end
            end
            S_SQE:
                state_next = S_SQP;
            S_SQP:
                state_next = S_RDS_GO;
            S_RDS_GO:
            begin
                cmd.start  = 1'b1;
                cmd.op     = jsf_pkg::OP_SQRT;
                cmd.nbits  = 6'd15;
                cmd.a      = {4'd0, acc_reg};
                state_next = S_RDS_WT;
            end
            S_RDS_WT:
            begin
                if (u_done)
                begin
                    dsum_next  = dsum_add[20] ? jsf_pkg::DSUM_MAX : dsum_add[19:0];
                    state_next = S_MEAN_GO;
                end
            end
            S_MEAN_GO:
            begin
                if (n_reg == 7'd0)
                    state_next = S_DEV;
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = jsf_pkg::OP_DIV;
                    cmd.nbits  = 6'd18;
                    cmd.a      = {24'd0, jpt_reg};
                    cmd.b      = {11'd0, n_reg};
                    state_next = S_MEAN_WT;
                end
            end
            S_MEAN_WT:
            begin
                if (u_done)
                    state_next = S_DEV;
            end
            S_DEV:
            begin
                ssum_next  = ssum_add[42] ? jsf_pkg::SSUM_MAX : ssum_add[41:0];
                state_next = last_reg ? S_FRAC_GO : S_IDLE;
            end
            S_FRAC_GO:
            begin
                if ((jpt_reg == 18'd0) || (lead_reg >= jpt_reg))
                    state_next = S_ANG_GO;
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = jsf_pkg::OP_DIV;
                    cmd.nbits  = 6'd34;
                    cmd.a      = {8'd0, lead_reg, 16'd0};
                    cmd.b      = jpt_reg;
                    state_next = S_FRAC_WT;
                end
            end
            S_FRAC_WT:
            begin
                if (u_done)
                    state_next = S_ANG_GO;
            end
            S_ANG_GO:
            begin
                if (n_reg == 7'd0)
                    state_next = S_OUT;
                else
                begin
                    cmd.start  = 1'b1;
                    cmd.op     = jsf_pkg::OP_DIV;
                    cmd.nbits  = 6'd20;
                    cmd.a      = {22'd0, dsum_reg};
                    cmd.b      = {11'd0, n_reg};
                    state_next = S_ANG_WT;
                end
            end
            S_ANG_WT:
            begin
                if (u_done)
                    state_next = S_SDIV_GO;
            end
            S_SDIV_GO:
            begin
                cmd.start  = 1'b1;
                cmd.op     = jsf_pkg::OP_DIV;
                cmd.nbits  = 6'd42;
                cmd.a      = ssum_reg;
                cmd.b      = {11'd0, n_reg};
                state_next = S_SDIV_WT;
            end
            S_SDIV_WT:
            begin
                if (u_done)
                    state_next = S_SPR_GO;
            end
            S_SPR_GO:
            begin
                // radicand is the quotient still held in the unit
                cmd.start  = 1'b1;
                cmd.op     = jsf_pkg::OP_SQRT;
                cmd.nbits  = 6'd21;
                cmd.a      = u_res;
                state_next = S_SPR_WT;
            end
            S_SPR_WT:
            begin
                if (u_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    seen_next     = 7'd0;
                    sec_next      = 7'd0;
                    peak_next     = 18'd0;
                    lead_next     = 18'd0;
                    dsum_next     = 20'd0;
                    ssum_next     = 42'd0;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            seen_reg       <= 7'd0;
            sec_reg        <= 7'd0;
            peak_reg       <= 18'd0;
            lead_reg       <= 18'd0;
            dsum_reg       <= 20'd0;
            ssum_reg       <= 42'd0;
            m_tvalid_reg   <= 1'b0;
            rho_min_reg    <= 18'd41;
            rho_max_reg    <= 18'd4096;
            jet_pt_min_reg <= 18'd1280;
        end
        else
        begin
            state_reg    <= state_next;
            seen_reg     <= seen_next;
            sec_reg      <= sec_next;
            peak_reg     <= peak_next;
            lead_reg     <= lead_next;
            dsum_reg     <= dsum_next;
            ssum_reg     <= ssum_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    jsf_pkg::REG_RHO_MIN:    rho_min_reg    <= cfg_data;
                    jsf_pkg::REG_RHO_MAX:    rho_max_reg    <= cfg_data;
                    jsf_pkg::REG_JET_PT_MIN: jet_pt_min_reg <= cfg_data;
                    default:                 ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            jpt_reg  <= in_jpt;
            ppt_reg  <= in_ppt;
            n_reg    <= in_n_clamp;
            ax_reg   <= ax_w;
            ay_reg   <= ay_w;
            deta_reg <= deta_w;
            dphi_reg <= dphi_w;
            last_reg <= s_tlast;
        end
        case (state_reg)
            S_SQX, S_SQE:
                acc_reg <= prod;
            S_SQY, S_SQP:
                acc_reg <= acc_reg + prod;
            S_MEAN_GO:
                mean_reg <= 18'd0;
            S_MEAN_WT:
                if (u_done)
                    mean_reg <= u_res[17:0];
            S_FRAC_GO:
            begin
                if (jpt_reg == 18'd0)
                    frac_reg <= 17'd0;
                else
                    frac_reg <= jsf_pkg::FRAC_ONE;
            end
            S_FRAC_WT:
                if (u_done)
                    frac_reg <= u_res[16:0];
            S_ANG_GO:
            begin
                ang_reg <= 14'd0;
                spr_reg <= 18'd0;
            end
            S_ANG_WT:
                if (u_done)
                    ang_reg <= (u_res > {28'd0, jsf_pkg::ANG_MAX})
                             ? jsf_pkg::ANG_MAX : u_res[13:0];
            S_SPR_WT:
                if (u_done)
                    spr_reg <= (u_res[20:18] != 3'd0) ? jsf_pkg::M18 : u_res[17:0];
            S_OUT:
                if (out_free)
                    m_tdata_reg <= {5'd0,
                                    ((n_reg == 7'd0) || (jpt_reg == 18'd0)),
                                    (jpt_reg > jet_pt_min_reg),
                                    spr_reg, ang_reg, frac_reg,
                                    peak_reg, sec_reg, seen_reg};
            default:
                ;
        endcase
    end

    // the shared unit only finishes while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> ((state_reg == S_RAD_WT) || (state_reg == S_RDS_WT)
                 || (state_reg == S_MEAN_WT) || (state_reg == S_FRAC_WT)
                 || (state_reg == S_ANG_WT) || (state_reg == S_SDIV_WT)
                 || (state_reg == S_SPR_WT)))
        else $error("shared unit finished outside a wait state");

    // delivering a jet clears its accumulators
    a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && out_free) |=>
            (m_tvalid && (seen_reg == 7'd0) && (dsum_reg == 20'd0)
             && (state_reg == S_IDLE)))
        else $error("accumulators not cleared after result");

    // a non-final item never raises a result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside output state");

endmodule
